// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are disabled while reset is applied.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Types, character codes and the word list of the shader tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int MAX_WORD_DEF = 16;
	localparam int WORD_BYTES   = 11;
	localparam int WORD_BITS    = 8 * WORD_BYTES;
	localparam int N_KEYWORDS   = 12;
	localparam int N_TYPES      = 14;
	localparam int N_WORDS      = 123;

	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_LF    = 16'h000A;
	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_QUOTE = 16'h0022;
	localparam logic [15:0] CH_LPAR  = 16'h0028;
	localparam logic [15:0] CH_RPAR  = 16'h0029;
	localparam logic [15:0] CH_DOT   = 16'h002E;
	localparam logic [15:0] CH_SLASH = 16'h002F;
	localparam logic [15:0] CH_ZERO  = 16'h0030;
	localparam logic [15:0] CH_NINE  = 16'h0039;
	localparam logic [15:0] CH_SEMI  = 16'h003B;

	typedef enum logic [2:0] {
		CLS_DEFAULT  = 3'd0,
		CLS_COMMENT  = 3'd1,
		CLS_STRING   = 3'd2,
		CLS_NUMBER   = 3'd3,
		CLS_KEYWORD  = 3'd4,
		CLS_TYPE     = 3'd5,
		CLS_FUNCTION = 3'd6
	} tok_class_t;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_COMMENT,
		MODE_STRING,
		MODE_NUMBER
	} scan_mode_t;

	typedef enum logic [3:0] {
		OP_DONE,
		OP_WAIT,
		OP_FINAL,
		OP_CMT_END,
		OP_BUMP_DROP,
		OP_STR_END,
		OP_NUM_END,
		OP_CMT_OPEN,
		OP_STR_OPEN,
		OP_NUM_OPEN,
		OP_WS,
		OP_MISS,
		OP_HIT,
		OP_SCAN
	} adv_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADVANCE,
		ST_SCAN,
		ST_DECIDE,
		ST_DROP,
		ST_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic scan_start;
		logic exec;
		logic dec_sel;
		logic pre;
		logic main_phase;
		logic append;
		logic scan_step;
		logic drop_step;
		logic flush;
	} stt_cmd_t;

	typedef struct packed {
		adv_op_t op;
		logic    op_emits;
		logic    can_emit;
		logic    out_free;
		logic    scan_end;
		logic    drop_last;
		logic    pend_valid;
		logic    full;
	} stt_stat_t;

	function automatic logic is_ws(input logic [15:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_delim(input logic [15:0] c);
		return is_ws(c) || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_SEMI);
	endfunction

	function automatic logic is_digit(input logic [15:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Word text, right-aligned with zero padding above.
	function automatic logic [WORD_BITS-1:0] word_raw(input int unsigned k);
		logic [WORD_BITS-1:0] r;
		r = '0;
		case (k)
			0: r = "break";     1: r = "case";      2: r = "const";     3: r = "continue";
			4: r = "else";      5: r = "for";       6: r = "if";        7: r = "return";
			8: r = "struct";    9: r = "switch";    10: r = "uniform";  11: r = "while";
			12: r = "cbuffer";  13: r = "float";    14: r = "float2";   15: r = "float3";
			16: r = "float4";   17: r = "float4x4"; 18: r = "half";     19: r = "half2";
			20: r = "half3";    21: r = "half4";    22: r = "half4x4";  23: r = "texture";
			24: r = "sampler";  25: r = "void";
			26: r = "abort";    27: r = "abs";      28: r = "acos";     29: r = "all";
			30: r = "any";      31: r = "asdouble"; 32: r = "asfloat";  33: r = "asin";
			34: r = "asint";    35: r = "asuint";   36: r = "atan";     37: r = "atan2";
			38: r = "ceil";     39: r = "clamp";    40: r = "clip";     41: r = "cos";
			42: r = "cosh";     43: r = "countbits"; 44: r = "cross";   45: r = "ddx";
			46: r = {"ddx_", "coarse"}; 47: r = {"ddx_", "fine"}; 48: r = "ddy";
			49: r = {"ddy_", "coarse"}; 50: r = {"ddy_", "fine"};
			51: r = "degrees";  52: r = "determinant"; 53: r = "discard";
			54: r = "distance"; 55: r = "dot";      56: r = "dst";      57: r = "errorf";
			58: r = "exp";      59: r = "exp2";     60: r = "floor";    61: r = "fma";
			62: r = "fmod";     63: r = "frac";     64: r = "frexp";    65: r = "fwidth";
			66: r = "isfinite"; 67: r = "isinf";    68: r = "isnan";    69: r = "ldexp";
			70: r = "length";   71: r = "lerp";     72: r = "lit";      73: r = "log";
			74: r = "log10";    75: r = "log2";     76: r = "mad";      77: r = "max";
			78: r = "min";      79: r = "modf";     80: r = "mul";      81: r = "noise";
			82: r = "normalize"; 83: r = "pow";     84: r = "printf";   85: r = "radians";
			86: r = "rcp";      87: r = "reflect";  88: r = "refract";  89: r = "round";
			90: r = "rsqrt";    91: r = "saturate"; 92: r = "sin";      93: r = "sincos";
			94: r = "sinh";     95: r = "smoothstep"; 96: r = "sqrt";   97: r = "step";
			98: r = "tan";      99: r = "tanh";     100: r = "tex1D";   101: r = "tex1Dbias";
			102: r = "tex1Dgrad"; 103: r = "tex1Dlod"; 104: r = "tex1Dproj"; 105: r = "tex2D";
			106: r = "tex2Dbias"; 107: r = "tex2Dgrad"; 108: r = "tex2Dlod"; 109: r = "tex2Dproj";
			110: r = "tex3D";   111: r = "tex3Dbias"; 112: r = "tex3Dlod"; 113: r = "tex3Dproj";
			114: r = "texCUBE"; 115: r = "texCUBEbias"; 116: r = "texCUBEgrad";
			117: r = "texCUBElod"; 118: r = "texCUBEproj"; 119: r = "transpose";
			120: r = "trunc";   121: r = "Texture";  122: r = "Sample";
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] word_len(input logic [WORD_BITS-1:0] raw);
		logic [3:0] n;
		n = '0;
		for (int b = 0; b < WORD_BYTES; b++) begin
			if (raw[8*b +: 8] != 8'h00) begin
				n = n + 4'd1;
			end
		end
		return n;
	endfunction

	// Word text, left-aligned: character p sits in byte WORD_BYTES-1-p.
	function automatic logic [WORD_BITS-1:0] word_text(input int unsigned k);
		logic [WORD_BITS-1:0] raw;
		raw = word_raw(k);
		return raw << (8 * (WORD_BYTES - int'(word_len(raw))));
	endfunction

	function automatic logic [2:0] word_cls(input int unsigned k);
		if (k < N_KEYWORDS) begin
			return CLS_KEYWORD;
		end else if (k < N_KEYWORDS + N_TYPES) begin
			return CLS_TYPE;
		end
		return CLS_FUNCTION;
	endfunction

endpackage

// ===== sv/stt_in_if.sv =====
// ----------------------------------------------------------------------------
// stt_in_if
// Character channel: one source character and its end-of-text mark per beat.
// ----------------------------------------------------------------------------
interface stt_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_code;
	logic        end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== sv/stt_out_if.sv =====
// ----------------------------------------------------------------------------
// stt_out_if
// Token channel: one token class, length and last mark per beat.
// ----------------------------------------------------------------------------
interface stt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_class;
	logic [15:0] token_length;
	logic        token_last;

	modport source (output valid, output token_class, output token_length,
		output token_last, input ready);
	modport sink (input valid, input token_class, input token_length,
		input token_last, output ready);
endinterface

// ===== sv/stt_dp.sv =====
// ----------------------------------------------------------------------------
// stt_dp
// Tokenizer datapath: lookahead buffer, scan mode, run counter, word
// candidate set, pending token and output register.
// ----------------------------------------------------------------------------
module stt_dp import stt_pkg::*; #(
	parameter int MAX_WORD = MAX_WORD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  stt_cmd_t    cmd,
	output stt_stat_t   stat,
	input  logic [15:0] in_char,
	input  logic        in_eot,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [2:0]  out_class,
	output logic [15:0] out_length,
	output logic        out_last
);

	localparam int CW = $clog2(MAX_WORD + 1);
	localparam int IW = $clog2(MAX_WORD);

	logic [15:0]        buf_q [MAX_WORD];
	logic [CW-1:0]      count_q;
	scan_mode_t         mode_q;
	logic [15:0]        run_q;
	logic [15:0]        ch_q;
	logic               eot_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      rem_q;
	logic [N_WORDS-1:0] cand_q;
	logic               pend_v_q;
	logic [2:0]         pend_cls_q;
	logic [15:0]        pend_len_q;
	logic               out_v_q;
	logic [2:0]         out_cls_q;
	logic [15:0]        out_len_q;
	logic               out_last_q;

	logic [15:0]        head;
	logic [15:0]        scan_char;
	logic [N_WORDS-1:0] hit;
	logic [N_WORDS-1:0] exact;
	logic [2:0]         exact_cls;
	logic               final_w;
	logic               full;
	adv_op_t            adv_op;
	adv_op_t            dec_op;
	adv_op_t            op;
	logic               emits;
	logic [2:0]         emit_cls;
	logic [15:0]        emit_len;
	logic [15:0]        run_inc;
	logic [CW-1:0]      rem_set;
	logic               wr_en;
	logic [15:0]        wr_data;
	logic               push;
	logic               to_out;
	logic               scan_init;

	assign head      = buf_q[0];
	assign scan_char = buf_q[i_q[IW-1:0]];
	assign final_w   = cmd.main_phase && eot_q;
	assign full      = (count_q == CW'(MAX_WORD));
	assign run_inc   = (run_q == 16'hFFFF) ? run_q : run_q + 16'd1;

	// Each list word filters itself against the buffered character at the scan index.
	for (genvar k = 0; k < N_WORDS; k++) begin : g_word
		localparam logic [WORD_BITS-1:0] TXT = word_text(k);
		localparam logic [CW-1:0]        LEN = CW'(word_len(word_raw(k)));
		logic [7:0] wc;

		always_comb begin
			wc = 8'h00;
			for (int p = 0; p < WORD_BYTES; p++) begin
				if (i_q == CW'(p)) begin
					wc = TXT[WORD_BITS-1-8*p -: 8];
				end
			end
		end

		assign hit[k]   = (wc != 8'h00) && (scan_char == {8'h00, wc});
		assign exact[k] = cand_q[k] && (i_q == LEN);
	end

	always_comb begin
		exact_cls = '0;
		for (int k = 0; k < N_WORDS; k++) begin
			if (exact[k]) begin
				exact_cls = exact_cls | word_cls(k);
			end
		end
	end

	// Decision for the head of the buffer.
	always_comb begin
		adv_op = OP_DONE;
		if (count_q == '0) begin
			adv_op = final_w ? OP_FINAL : OP_DONE;
		end else begin
			unique case (mode_q)
				MODE_COMMENT: adv_op = (head == CH_LF || head == CH_CR) ? OP_CMT_END
					: OP_BUMP_DROP;
				MODE_STRING: adv_op = (head == CH_QUOTE) ? OP_STR_END : OP_BUMP_DROP;
				MODE_NUMBER: adv_op = (is_digit(head) || head == CH_DOT) ? OP_BUMP_DROP
					: OP_NUM_END;
				MODE_START: begin
					priority if (head == CH_SLASH && count_q < CW'(2) && !final_w) begin
						adv_op = OP_DONE;
					end else if (head == CH_SLASH && count_q >= CW'(2)
						&& buf_q[1] == CH_SLASH) begin
						adv_op = OP_CMT_OPEN;
					end else if (head == CH_QUOTE) begin
						adv_op = OP_STR_OPEN;
					end else if (is_digit(head)) begin
						adv_op = OP_NUM_OPEN;
					end else if (is_ws(head)) begin
						adv_op = OP_WS;
					end else begin
						adv_op = OP_SCAN;
					end
				end
			endcase
		end
	end

	// Decision after a word scan has stopped at index i_q.
	always_comb begin
		priority if (cmd.pre) begin
			dec_op = (is_delim(ch_q) && exact_cls != '0) ? OP_HIT : OP_MISS;
		end else if (i_q == count_q && !final_w) begin
			dec_op = (|cand_q) ? OP_WAIT : OP_MISS;
		end else begin
			dec_op = (exact_cls != '0) ? OP_HIT : OP_MISS;
		end
	end

	assign op = cmd.dec_sel ? dec_op : adv_op;

	always_comb begin
		emits    = 1'b1;
		emit_cls = CLS_DEFAULT;
		emit_len = 16'd1;
		rem_set  = '0;
		unique case (op)
			OP_FINAL: begin
				emits    = (mode_q != MODE_START);
				emit_len = run_q;
				unique case (mode_q)
					MODE_COMMENT: emit_cls = CLS_COMMENT;
					MODE_STRING:  emit_cls = CLS_STRING;
					MODE_NUMBER:  emit_cls = CLS_NUMBER;
					MODE_START:   emit_cls = CLS_DEFAULT;
				endcase
			end
			OP_CMT_END: begin
				emit_cls = CLS_COMMENT;
				emit_len = run_q;
			end
			OP_STR_END: begin
				emit_cls = CLS_STRING;
				emit_len = run_inc;
				rem_set  = CW'(1);
			end
			OP_NUM_END: begin
				emit_cls = CLS_NUMBER;
				emit_len = run_q;
			end
			OP_WS, OP_MISS: rem_set = CW'(1);
			OP_HIT: begin
				emit_cls = exact_cls;
				emit_len = 16'(i_q);
				rem_set  = i_q;
			end
			OP_BUMP_DROP, OP_STR_OPEN, OP_NUM_OPEN: begin
				emits   = 1'b0;
				rem_set = CW'(1);
			end
			OP_CMT_OPEN: begin
				emits   = 1'b0;
				rem_set = CW'(2);
			end
			default: emits = 1'b0;
		endcase
	end

	assign wr_en     = (cmd.accept && !full) || cmd.append;
	assign wr_data   = cmd.accept ? in_char : ch_q;
	assign push      = cmd.exec && emits;
	assign to_out    = (push && pend_v_q) || cmd.flush;
	assign scan_init = cmd.scan_start || (cmd.exec && op == OP_SCAN);

	always_comb begin
		stat.op         = op;
		stat.op_emits   = emits;
		stat.out_free   = !out_v_q || out_ready;
		stat.can_emit   = !pend_v_q || !out_v_q || out_ready;
		stat.scan_end   = (i_q == count_q) || is_delim(scan_char);
		stat.drop_last  = (rem_q <= CW'(1));
		stat.pend_valid = pend_v_q;
		stat.full       = full;
	end

	always_ff @(posedge clk) begin
		if (cmd.drop_step) begin
			for (int j = 0; j < MAX_WORD - 1; j++) begin
				buf_q[j] <= buf_q[j+1];
			end
		end else if (wr_en) begin
			buf_q[count_q[IW-1:0]] <= wr_data;
		end
		if (cmd.accept) begin
			ch_q <= in_char;
		end
		if (scan_init) begin
			cand_q <= '1;
		end else if (cmd.scan_step) begin
			cand_q <= cand_q & hit;
		end
		if (push) begin
			pend_cls_q <= emit_cls;
			pend_len_q <= emit_len;
		end
		if (to_out) begin
			out_cls_q  <= pend_cls_q;
			out_len_q  <= pend_len_q;
			out_last_q <= cmd.flush && eot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mode_q   <= MODE_START;
			run_q    <= '0;
			eot_q    <= 1'b0;
			i_q      <= '0;
			rem_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				eot_q <= in_eot;
			end
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.drop_step) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.exec && op == OP_FINAL) begin
				count_q <= '0;
			end
			if (scan_init) begin
				i_q <= '0;
			end else if (cmd.scan_step) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.exec) begin
				rem_q <= rem_set;
				unique case (op)
					OP_FINAL: begin
						mode_q <= MODE_START;
						run_q  <= '0;
					end
					OP_CMT_END, OP_NUM_END: mode_q <= MODE_START;
					OP_STR_END: begin
						mode_q <= MODE_START;
						run_q  <= run_inc;
					end
					OP_BUMP_DROP: run_q <= run_inc;
					OP_CMT_OPEN: begin
						mode_q <= MODE_COMMENT;
						run_q  <= 16'd2;
					end
					OP_STR_OPEN: begin
						mode_q <= MODE_STRING;
						run_q  <= 16'd1;
					end
					OP_NUM_OPEN: begin
						mode_q <= MODE_NUMBER;
						run_q  <= 16'd1;
					end
					default: begin
					end
				endcase
			end else if (cmd.drop_step) begin
				rem_q <= rem_q - CW'(1);
			end
			if (push) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (to_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign out_class  = out_cls_q;
	assign out_length = out_len_q;
	assign out_last   = out_last_q;

endmodule

// ===== sv/stt_ctrl.sv =====
// ----------------------------------------------------------------------------
// stt_ctrl
// Tokenizer sequencer: takes one character, then steps the datapath through
// head decisions, word scans, buffer drops and the final token flush.
// ----------------------------------------------------------------------------
module stt_ctrl import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  stt_stat_t stat,
	output stt_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        main_q, main_d;
	logic        pre_q, pre_d;
	logic        exec_ok;

	// A decision that makes a token waits for room in the pending/output pair.
	assign exec_ok = !stat.op_emits || stat.can_emit;

	always_comb begin
		state_d = state_q;
		main_d  = main_q;
		pre_d   = pre_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.full) begin
						pre_d   = 1'b1;
						main_d  = 1'b0;
						state_d = ST_SCAN;
					end else begin
						main_d  = 1'b1;
						state_d = ST_ADVANCE;
					end
				end
			end
			ST_ADVANCE, ST_DECIDE: begin
				if (exec_ok) begin
					if (state_q == ST_DECIDE) begin
						pre_d = 1'b0;
					end
					unique case (stat.op)
						OP_DONE, OP_WAIT: begin
							if (main_q) begin
								state_d = ST_FLUSH;
							end else begin
								main_d  = 1'b1;
								state_d = ST_ADVANCE;
							end
						end
						OP_FINAL: state_d = ST_FLUSH;
						OP_SCAN:  state_d = ST_SCAN;
						// Closing a comment or number leaves its terminator at the head.
						OP_CMT_END, OP_NUM_END: state_d = ST_ADVANCE;
						default:  state_d = ST_DROP;
					endcase
				end
			end
			ST_SCAN: begin
				if (stat.scan_end) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DROP: begin
				if (stat.drop_last) begin
					state_d = ST_ADVANCE;
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_valid || stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.pre        = pre_q;
		cmd.main_phase = main_q;
		in_ready       = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept     = in_valid;
				cmd.scan_start = in_valid && stat.full;
			end
			ST_ADVANCE, ST_DECIDE: begin
				cmd.dec_sel = (state_q == ST_DECIDE);
				cmd.exec    = exec_ok;
				cmd.append  = exec_ok && !main_q
					&& (stat.op == OP_DONE || stat.op == OP_WAIT);
			end
			ST_SCAN:  cmd.scan_step = !stat.scan_end;
			ST_DROP:  cmd.drop_step = 1'b1;
			ST_FLUSH: cmd.flush     = stat.pend_valid && stat.out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			main_q  <= 1'b0;
			pre_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			main_q  <= main_d;
			pre_q   <= pre_d;
		end
	end

endmodule

// ===== sv/shader_syntax_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// shader_syntax_tokenizer_unit
// Streaming syntax-highlighting tokenizer for shader source text.
//
// Channel   Dir  Beat contents
// in_ch     in   char_code[15:0], end_of_text
// out_ch    out  token_class[2:0], token_length[15:0], token_last
//
// One character at a time is taken; the next is taken once every token it
// decides sits in the pending or output register. A character that extends
// a comment, string or number passes through acceptance, a head decision,
// a drop, a second head decision and the flush; a word scan runs a head
// decision, the scan steps and a decision, then drops each consumed character.
// Reset leaves an empty buffer at token start. A stalled output holds the
// sequencer but not tokens already buffered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shader_syntax_tokenizer_unit import stt_pkg::*; #(
	parameter int MAX_WORD = MAX_WORD_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	stt_in_if.sink   in_ch,
	stt_out_if.source out_ch
);

	stt_cmd_t  cmd;
	stt_stat_t stat;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stt_dp #(
		.MAX_WORD (MAX_WORD)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_char    (in_ch.char_code),
		.in_eot     (in_ch.end_of_text),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_class  (out_ch.token_class),
		.out_length (out_ch.token_length),
		.out_last   (out_ch.token_last)
	);

	`STT_ASSERT_NXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "second beat taken during work")
	`STT_ASSERT_IMP(a_emit_room, cmd.exec && stat.op_emits, stat.can_emit, "token made without room")
	`STT_ASSERT_IMP(a_default_len, out_ch.valid && out_ch.token_class == CLS_DEFAULT, out_ch.token_length == 16'd1, "default token longer than one")

endmodule
